FILE: hdl/srad_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and the sideband struct of the stick deadzone pipeline.
// No dependencies.
package srad_pkg;

   localparam int SW = 16;
   localparam int FB = SW - 1;
   localparam int DW = 2 * SW;
   localparam logic [SW-1:0] ONE_Q = SW'(1) << FB;
   localparam logic [FB-1:0] DZ_RESET = FB'(3277);

   typedef struct packed {
      logic          valid;
      logic          neg_x;
      logic          neg_y;
      logic          live;
      logic [SW-1:0] abs_x;
      logic [SW-1:0] abs_y;
      logic [SW-1:0] m;
      logic [SW-1:0] ax;
      logic [SW-1:0] ay;
      logic          sat_r;
      logic          gt_x;
      logic          gt_y;
      logic          sat_x;
      logic          sat_y;
   } side_type;

endpackage

FILE: hdl/stick_radial_axial_deadzone_top.sv
`timescale 1ns / 1ps
// Two-axis stick conditioner: scaled radial deadzone, then sloped axial deadzones.
// Depends on srad_pkg, srad_sqrt and srad_div.
//
// Takes one sample per clock cycle and returns one result per sample, in order, through
// a 16-stage square root and three 16-stage dividers in series. The whole pipeline
// holds when the result side stalls. The deadzone register resets to 0.1 and may be
// rewritten only while the pipeline is empty.
module stick_radial_axial_deadzone_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // stick_x [15:0], stick_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_x [15:0], out_y [31:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data    // deadzone [14:0]
);
   import srad_pkg::*;

   logic            adv;
   logic [FB-1:0]   dz_ff;
   logic [2*FB-1:0] dd_ff;

   logic [SW-1:0]   x_in, y_in;
   side_type        s1_ff, s1_in;
   side_type        s2_ff, s3_ff, s3_in, sq_side;
   logic [DW-1:0]   sqx_ff, sqy_ff, m2_ff, m2_in;
   logic [SW-1:0]   root;
   side_type        s4_ff, s4_in, r_side;
   logic [DW-1:0]   nr_ff, nr_in;
   logic [SW-1:0]   dr_ff, q_r;
   side_type        s5_ff;
   logic [SW-1:0]   r_ff, r_in;
   side_type        s6_ff;
   logic [DW-1:0]   px_ff, py_ff;
   logic [SW-1:0]   dm_ff;
   side_type        dx_side;
   logic [SW-1:0]   q_ax, q_ay;
   side_type        s7_ff, s7_in;
   side_type        s8_ff;
   logic [SW-1:0]   dzx_ff, dzy_ff;
   logic [DW-1:0]   dzxp, dzyp;
   side_type        s9_ff, s9_in;
   logic [DW-1:0]   nx_ff, ny_ff, nx_in, ny_in;
   logic [SW-1:0]   ex_ff, ey_ff;
   side_type        o_side;
   logic [SW-1:0]   q_ox, q_oy;
   logic            rsp_valid_ff;
   logic [SW-1:0]   ox_ff, oy_ff, ox_in, oy_in;

   function automatic logic [SW-1:0] finish(input logic live, input logic gt,
                                            input logic sat, input logic neg,
                                            input logic [SW-1:0] q);
      logic [SW-1:0] mag;
      mag = sat ? ONE_Q : q;
      if (!live || !gt) begin
         return '0;
      end else if (neg) begin
         return SW'(-mag);
      end else if (mag == ONE_Q) begin
         return ONE_Q - SW'(1);
      end else begin
         return mag;
      end
   endfunction

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DZ_RESET;
         dd_ff <= (2*FB)'(DZ_RESET) * (2*FB)'(DZ_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            dz_ff <= csr_data[FB-1:0];
         end
         dd_ff <= (2*FB)'(dz_ff) * (2*FB)'(dz_ff);
      end
   end

   // stage 1: magnitudes and signs
   always_comb begin
      x_in        = req_tdata[SW-1:0];
      y_in        = req_tdata[DW-1:SW];
      s1_in       = '0;
      s1_in.valid = req_tvalid;
      s1_in.neg_x = x_in[SW-1];
      s1_in.neg_y = y_in[SW-1];
      s1_in.abs_x = x_in[SW-1] ? SW'(-x_in) : x_in;
      s1_in.abs_y = y_in[SW-1] ? SW'(-y_in) : y_in;
   end

   // stage 3: squared magnitude and radial test
   always_comb begin
      m2_in      = sqx_ff + sqy_ff;
      s3_in      = s2_ff;
      s3_in.live = (m2_in >= DW'(dd_ff)) && (m2_in != '0);
   end

   // stage 4: radial remap dividend
   always_comb begin
      s4_in       = sq_side;
      s4_in.m     = root;
      s4_in.sat_r = (root >= ONE_Q);
      if (s4_in.sat_r || !sq_side.live) begin
         nr_in = '0;
      end else begin
         nr_in = DW'({root - SW'(dz_ff), FB'(0)});
      end
   end

   assign r_in = r_side.sat_r ? ONE_Q : q_r;

   // stage 7 to 9: axis values, axial deadzones, axial remap dividends
   always_comb begin
      s7_in    = dx_side;
      s7_in.ax = q_ax;
      s7_in.ay = q_ay;
      dzxp     = DW'(dz_ff) * DW'(s7_ff.ay);
      dzyp     = DW'(dz_ff) * DW'(s7_ff.ax);
      s9_in       = s8_ff;
      s9_in.gt_x  = (s8_ff.ax > dzx_ff);
      s9_in.gt_y  = (s8_ff.ay > dzy_ff);
      s9_in.sat_x = (s8_ff.ax >= ONE_Q);
      s9_in.sat_y = (s8_ff.ay >= ONE_Q);
      nx_in = s9_in.gt_x ? DW'({s8_ff.ax - dzx_ff, FB'(0)}) : '0;
      ny_in = s9_in.gt_y ? DW'({s8_ff.ay - dzy_ff, FB'(0)}) : '0;
   end

   always_comb begin
      ox_in = finish(o_side.live, o_side.gt_x, o_side.sat_x, o_side.neg_x, q_ox);
      oy_in = finish(o_side.live, o_side.gt_y, o_side.sat_y, o_side.neg_y, q_oy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
         s5_ff        <= '0;
         s6_ff        <= '0;
         s7_ff        <= '0;
         s8_ff        <= '0;
         s9_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         s3_ff        <= s3_in;
         s4_ff        <= s4_in;
         s5_ff        <= r_side;
         s6_ff        <= s5_ff;
         s7_ff        <= s7_in;
         s8_ff        <= s7_ff;
         s9_ff        <= s9_in;
         rsp_valid_ff <= o_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= DW'(s1_ff.abs_x) * DW'(s1_ff.abs_x);
         sqy_ff <= DW'(s1_ff.abs_y) * DW'(s1_ff.abs_y);
         m2_ff  <= m2_in;
         nr_ff  <= nr_in;
         dr_ff  <= ONE_Q - SW'(dz_ff);
         r_ff   <= r_in;
         px_ff  <= DW'(s5_ff.abs_x) * DW'(r_ff);
         py_ff  <= DW'(s5_ff.abs_y) * DW'(r_ff);
         dm_ff  <= s5_ff.live ? s5_ff.m : SW'(1);
         dzx_ff <= dzxp[FB+SW-1:FB];
         dzy_ff <= dzyp[FB+SW-1:FB];
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         ex_ff  <= ONE_Q - dzx_ff;
         ey_ff  <= ONE_Q - dzy_ff;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

   srad_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .rad_i  (m2_ff),
      .side_i (s3_ff),
      .root_o (root),
      .side_o (sq_side)
   );

   srad_div u_div_r (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .num_i  (nr_ff),
      .den_i  (dr_ff),
      .side_i (s4_ff),
      .quo_o  (q_r),
      .side_o (r_side)
   );

   srad_div u_div_ax (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .num_i  (px_ff),
      .den_i  (dm_ff),
      .side_i (s6_ff),
      .quo_o  (q_ax),
      .side_o (dx_side)
   );

   srad_div u_div_ay (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .num_i  (py_ff),
      .den_i  (dm_ff),
      .side_i (s6_ff),
      .quo_o  (q_ay),
      .side_o ()
   );

   srad_div u_div_ox (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .num_i  (nx_ff),
      .den_i  (ex_ff),
      .side_i (s9_ff),
      .quo_o  (q_ox),
      .side_o (o_side)
   );

   srad_div u_div_oy (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .num_i  (ny_ff),
      .den_i  (ey_ff),
      .side_i (s9_ff),
      .quo_o  (q_oy),
      .side_o ()
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {oy_ff, ox_ff};

endmodule

FILE: hdl/srad_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on srad_pkg.
module srad_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [srad_pkg::DW-1:0] rad_i,
   input  srad_pkg::side_type      side_i,
   output logic [srad_pkg::SW-1:0] root_o,
   output srad_pkg::side_type      side_o
);
   import srad_pkg::*;

   localparam int RW = SW + 3;

   logic [RW-1:0] rem_ff  [SW];
   logic [SW-1:0] root_ff [SW];
   logic [DW-1:0] rad_ff  [SW];
   side_type      side_ff [SW];
   logic [RW-1:0] rem_in  [SW];
   logic [SW-1:0] root_in [SW];
   logic [DW-1:0] rad_in  [SW];
   side_type      side_in [SW];

   always_comb begin
      logic [RW-1:0] rem_p;
      logic [SW-1:0] root_p;
      logic [DW-1:0] rad_p;
      logic [RW-1:0] acc;
      logic [RW-1:0] trial;
      logic          ge;
      for (int i = 0; i < SW; i++) begin
         if (i == 0) begin
            rem_p      = '0;
            root_p     = '0;
            rad_p      = rad_i;
            side_in[i] = side_i;
         end else begin
            rem_p      = rem_ff[i-1];
            root_p     = root_ff[i-1];
            rad_p      = rad_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         acc        = {rem_p[RW-3:0], rad_p[DW-1:DW-2]};
         trial      = RW'({root_p, 2'b01});
         ge         = (acc >= trial);
         rem_in[i]  = ge ? acc - trial : acc;
         root_in[i] = {root_p[SW-2:0], ge};
         rad_in[i]  = {rad_p[DW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SW; i++) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (adv) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign root_o = root_ff[SW-1];
   assign side_o = side_ff[SW-1];

endmodule

FILE: hdl/srad_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage; needs num < den * 2^SW.
// Depends on srad_pkg.
module srad_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [srad_pkg::DW-1:0] num_i,
   input  logic [srad_pkg::SW-1:0] den_i,
   input  srad_pkg::side_type      side_i,
   output logic [srad_pkg::SW-1:0] quo_o,
   output srad_pkg::side_type      side_o
);
   import srad_pkg::*;

   logic [SW-1:0] rem_ff  [SW];
   logic [SW-1:0] low_ff  [SW];
   logic [SW-1:0] den_ff  [SW];
   side_type      side_ff [SW];
   logic [SW-1:0] rem_in  [SW];
   logic [SW-1:0] low_in  [SW];
   logic [SW-1:0] den_in  [SW];
   side_type      side_in [SW];

   always_comb begin
      logic [SW-1:0] rem_p;
      logic [SW-1:0] low_p;
      logic [SW:0]   acc;
      logic          ge;
      for (int i = 0; i < SW; i++) begin
         if (i == 0) begin
            rem_p      = num_i[DW-1:SW];
            low_p      = num_i[SW-1:0];
            den_in[i]  = den_i;
            side_in[i] = side_i;
         end else begin
            rem_p      = rem_ff[i-1];
            low_p      = low_ff[i-1];
            den_in[i]  = den_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         acc       = {rem_p, low_p[SW-1]};
         ge        = (acc >= {1'b0, den_in[i]});
         rem_in[i] = ge ? SW'(acc - {1'b0, den_in[i]}) : acc[SW-1:0];
         low_in[i] = {low_p[SW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SW; i++) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (adv) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         den_ff <= den_in;
      end
   end

   assign quo_o  = low_ff[SW-1];
   assign side_o = side_ff[SW-1];

endmodule
